FILE: design/jlr3d_pkg.sv
// ----------------------------------------------------------------------------
// jlr3d_pkg
// Shared types and constants for the 3D Jacobi Laplace relaxation core.
// ----------------------------------------------------------------------------
package jlr3d_pkg;

    // Command codes carried in the mode field of an input beat.
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_RELAX = 2'd2,
        MODE_RESET = 2'd3
    } jlr3d_mode_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIDE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd1;
    localparam logic [1:0] CFG_MAX_SWEEPS  = 2'd2;

    // Configuration reset values.
    localparam logic [4:0]  SIDE_LENGTH_RST = 5'd5;
    localparam logic [15:0] TOLERANCE_RST   = 16'd328;
    localparam logic [7:0]  MAX_SWEEPS_RST  = 8'd30;

    // Face neighbour codes, in the order they are fetched.
    localparam logic [2:0] NBR_XM = 3'd0;
    localparam logic [2:0] NBR_XP = 3'd1;
    localparam logic [2:0] NBR_YM = 3'd2;
    localparam logic [2:0] NBR_YP = 3'd3;
    localparam logic [2:0] NBR_ZM = 3'd4;
    localparam logic [2:0] NBR_ZP = 3'd5;

    // Field widths of the stream beats.
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 4;
    localparam int POT_W      = 16;
    localparam int SWEEPS_W   = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SW_START,
        ST_SW_CHK,
        ST_SW_NB,
        ST_SW_MUL,
        ST_SW_WR,
        ST_SW_END,
        ST_RS_START,
        ST_RS_CHK,
        ST_EMIT
    } jlr3d_state_t;

endpackage

FILE: design/jacobi_laplace_relaxation_3d_core.sv
// ----------------------------------------------------------------------------
// jacobi_laplace_relaxation_3d_core
// Cubic potential grid with cell access and Jacobi relaxation of the Laplace
// equation over the six face neighbours, double buffered in two memories.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                           | Beat content
//  ---------+-----------+-----------------------------------+------------------------
//  s_*      | in        | s_tvalid, s_tready, s_tdata[31:0] | one command
//  m_*      | out       | m_tvalid, m_tready, m_tdata[31:0] | one result per command
//  cfg_*    | in        | cfg_valid, cfg_ready, cfg_index,  | one register write
//           |           | cfg_data                          |
//
// A write command passes from idle straight to the emit state, and a read command
// also through a read state, the extra one being the registered read port of the
// grid memory. Reset of free cells walks every memory entry at one per cycle.
// A relax sweep visits every memory entry: fixed cells and cells outside the cube
// interior are copied over directly, while a free interior cell passes through the
// center fetch, six neighbour fetches on the single read port, the registered
// multiply by one sixth, and the write-back; each sweep adds a start and an end state.
// Reset clears the control state and sets the configuration to its reset values;
// the memories are not cleared and hold garbage until written. A stalled output
// holds the finished result in its register while the next command may already be
// accepted; that command then waits for the register to drain before it completes.
//
module jacobi_laplace_relaxation_3d_core
    import jlr3d_pkg::*;
#(
    parameter int MAX_SIDE   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Command stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] mode, [5:2] cell_x, [9:6] cell_y, [13:10] cell_z,
    // [29:14] write_value, [31:30] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] read_value, [23:16] sweeps_done, [24] still_changing, [31:25] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    // Coordinates are packed as {z, y, x} so no multiply is needed for an address.
    localparam int XW    = $clog2(MAX_SIDE);
    localparam int AW    = 3 * XW;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = $clog2(MAX_SIDE + 1);
    localparam int VB    = VALUE_BITS;
    localparam int SUMW  = VALUE_BITS + 3;
    localparam int DW    = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam logic [XW-1:0] LAST   = XW'(MAX_SIDE - 1);
    localparam logic [VB-1:0] HALF   = VB'(1) << (VB - 1);

    // Grid memories: one holds the present grid, the other receives a sweep.
    logic [VB-1:0] grid_a_mem [DEPTH];
    logic [VB-1:0] grid_b_mem [DEPTH];
    logic [VB-1:0] q_a_reg;
    logic [VB-1:0] q_b_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [VB-1:0] wr_data;
    logic          wr_en;
    logic          wr_sel;
    logic          we_a;
    logic          we_b;

    jlr3d_state_t state_reg, state_next;

    logic          cur_reg, cur_next;
    logic [4:0]    side_reg;
    logic [15:0]   tol_reg;
    logic [7:0]    maxsw_reg;

    logic [XW-1:0] cx_reg, cx_next;
    logic [XW-1:0] cy_reg, cy_next;
    logic [XW-1:0] cz_reg, cz_next;
    logic [2:0]    nbr_reg, nbr_next;
    logic [7:0]    loops_reg, loops_next;
    logic          moving_reg, moving_next;
    logic          inside_reg, inside_next;
    logic [VB-1:0] center_reg, center_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [POT_W-1:0] value_reg, value_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic          out_load;

    // Unpacked command fields.
    jlr3d_mode_t       in_mode;
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [POT_W-1:0]  in_wv;
    logic              in_inside;
    logic [AW-1:0]     in_addr;

    logic [6:0]    side_ext;
    logic [EW-1:0] eff_side;
    logic [EW-1:0] side_m1;
    logic [7:0]    max_eff;
    logic [7:0]    loops_inc;

    logic [XW-1:0] cx_inc, cy_inc, cz_inc;
    logic          cnt_last;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] next_addr;
    logic          cell_interior;

    logic [2:0]    nbr_k;
    logic [XW-1:0] nx, ny, nz;
    logic [AW-1:0] nbr_addr;

    logic [VB-1:0] rd_data;
    logic          val_free;
    logic [VB-1:0] mean;
    logic [VB-1:0] delta;

    assign in_mode  = jlr3d_mode_t'(s_tdata[1:0]);
    assign in_x     = s_tdata[5:2];
    assign in_y     = s_tdata[9:6];
    assign in_z     = s_tdata[13:10];
    assign in_wv    = s_tdata[29:14];
    assign in_addr  = {XW'(in_z), XW'(in_y), XW'(in_x)};

    // Side in use, clamped to the supported range.
    always_comb
    begin
        side_ext = 7'(side_reg);
        if (side_ext < 7'd3)
        begin
            eff_side = EW'(3);
        end
        else if (side_ext > 7'(MAX_SIDE))
        begin
            eff_side = EW'(MAX_SIDE);
        end
        else
        begin
            eff_side = EW'(side_reg);
        end
    end

    assign side_m1   = eff_side - EW'(1);
    assign in_inside = (7'(in_x) < 7'(eff_side)) && (7'(in_y) < 7'(eff_side))
                    && (7'(in_z) < 7'(eff_side));
    assign max_eff   = (maxsw_reg == 8'd0) ? 8'd1 : maxsw_reg;
    assign loops_inc = loops_reg + 8'd1;

    // Raster walk over the memory, x fastest.
    assign cx_inc   = (cx_reg == LAST) ? '0 : cx_reg + XW'(1);
    assign cy_inc   = (cx_reg == LAST) ? ((cy_reg == LAST) ? '0 : cy_reg + XW'(1)) : cy_reg;
    assign cz_inc   = (cx_reg == LAST && cy_reg == LAST)
                    ? ((cz_reg == LAST) ? '0 : cz_reg + XW'(1)) : cz_reg;
    assign cnt_last = (cx_reg == LAST) && (cy_reg == LAST) && (cz_reg == LAST);
    assign cell_addr = {cz_reg, cy_reg, cx_reg};
    assign next_addr = {cz_inc, cy_inc, cx_inc};

    // Interior of the cube in use: every coordinate strictly between the shells.
    assign cell_interior = (cx_reg != '0) && (EW'(cx_reg) < side_m1)
                        && (cy_reg != '0) && (EW'(cy_reg) < side_m1)
                        && (cz_reg != '0) && (EW'(cz_reg) < side_m1);

    // Neighbour address; only interior cells fetch neighbours, so no wrap occurs.
    assign nbr_k = (state_reg == ST_SW_NB) ? nbr_reg + 3'd1 : NBR_XM;

    always_comb
    begin
        nx = cx_reg;
        ny = cy_reg;
        nz = cz_reg;
        case (nbr_k)
            NBR_XM:  nx = cx_reg - XW'(1);
            NBR_XP:  nx = cx_reg + XW'(1);
            NBR_YM:  ny = cy_reg - XW'(1);
            NBR_YP:  ny = cy_reg + XW'(1);
            NBR_ZM:  nz = cz_reg - XW'(1);
            NBR_ZP:  nz = cz_reg + XW'(1);
            default: nx = cx_reg;
        endcase
    end

    assign nbr_addr = {nz, ny, nx};

    // The present grid is always the one read; a sweep writes the other one.
    assign rd_data  = cur_reg ? q_b_reg : q_a_reg;
    assign val_free = (rd_data != '0) && (rd_data != '1);
    assign delta    = (center_reg > mean) ? center_reg - mean : mean - center_reg;

    jlr3d_div6 #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div6 (
        .clk  (clk),
        .sum  (sum_reg),
        .mean (mean)
    );

    // Next-state and datapath control.
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        nbr_next      = nbr_reg;
        loops_next    = loops_reg;
        moving_next   = moving_reg;
        inside_next   = inside_reg;
        center_next   = center_reg;
        sum_next      = sum_reg;
        value_next    = value_reg;
        rd_addr       = cell_addr;
        wr_en         = 1'b0;
        wr_sel        = cur_reg;
        wr_addr       = cell_addr;
        wr_data       = rd_data;
        s_tready      = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_addr  = in_addr;
                if (s_tvalid)
                begin
                    value_next  = '0;
                    loops_next  = '0;
                    moving_next = 1'b0;
                    cx_next     = '0;
                    cy_next     = '0;
                    cz_next     = '0;
                    case (in_mode)
                        MODE_WRITE:
                        begin
                            wr_en      = in_inside;
                            wr_addr    = in_addr;
                            wr_data    = VB'(in_wv);
                            state_next = ST_EMIT;
                        end
                        MODE_READ:
                        begin
                            inside_next = in_inside;
                            state_next  = ST_RD;
                        end
                        MODE_RELAX: state_next = ST_SW_START;
                        MODE_RESET: state_next = ST_RS_START;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD:
            begin
                value_next = inside_reg ? POT_W'(rd_data) : '0;
                state_next = ST_EMIT;
            end
            ST_SW_START:
            begin
                moving_next = 1'b0;
                state_next  = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                if (cell_interior && val_free)
                begin
                    center_next = rd_data;
                    sum_next    = '0;
                    nbr_next    = NBR_XM;
                    rd_addr     = nbr_addr;
                    state_next  = ST_SW_NB;
                end
                else
                begin
                    // Fixed or non-interior cell: carry it over to the other buffer.
                    wr_en   = 1'b1;
                    wr_sel  = ~cur_reg;
                    cx_next = cx_inc;
                    cy_next = cy_inc;
                    cz_next = cz_inc;
                    rd_addr = next_addr;
                    if (cnt_last)
                    begin
                        state_next = ST_SW_END;
                    end
                end
            end
            ST_SW_NB:
            begin
                sum_next = sum_reg + SUMW'(rd_data);
                if (nbr_reg == NBR_ZP)
                begin
                    state_next = ST_SW_MUL;
                end
                else
                begin
                    nbr_next = nbr_reg + 3'd1;
                    rd_addr  = nbr_addr;
                end
            end
            ST_SW_MUL:
            begin
                state_next = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                wr_en   = 1'b1;
                wr_sel  = ~cur_reg;
                wr_data = mean;
                if (DW'(delta) >= DW'(tol_reg))
                begin
                    moving_next = 1'b1;
                end
                cx_next = cx_inc;
                cy_next = cy_inc;
                cz_next = cz_inc;
                rd_addr = next_addr;
                state_next = cnt_last ? ST_SW_END : ST_SW_CHK;
            end
            ST_SW_END:
            begin
                cur_next   = ~cur_reg;
                loops_next = loops_inc;
                if (moving_reg && (loops_inc < max_eff))
                begin
                    state_next = ST_SW_START;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RS_START:
            begin
                state_next = ST_RS_CHK;
            end
            ST_RS_CHK:
            begin
                if (cell_interior && val_free)
                begin
                    wr_en   = 1'b1;
                    wr_data = HALF;
                end
                cx_next = cx_inc;
                cy_next = cy_inc;
                cz_next = cz_inc;
                rd_addr = next_addr;
                if (cnt_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign we_a = wr_en && !wr_sel;
    assign we_b = wr_en && wr_sel;

    // Output register: loads a finished result, drains on the consumer's ready.
    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, moving_reg, loops_reg, value_reg};
        end
        else
        begin
            m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
            m_tdata_next  = m_tdata_reg;
        end
    end

    // Memories. Reads come from one buffer; only a write command reads an entry in
    // the cycle it writes it, and it ignores that data, so no forwarding path is needed.
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            grid_a_mem[wr_addr] <= wr_data;
        end
        q_a_reg <= grid_a_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            grid_b_mem[wr_addr] <= wr_data;
        end
        q_b_reg <= grid_b_mem[rd_addr];
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= 1'b0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            cz_reg       <= '0;
            nbr_reg      <= '0;
            loops_reg    <= '0;
            moving_reg   <= 1'b0;
            inside_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cur_reg      <= cur_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            cz_reg       <= cz_next;
            nbr_reg      <= nbr_next;
            loops_reg    <= loops_next;
            moving_reg   <= moving_next;
            inside_reg   <= inside_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        center_reg  <= center_next;
        sum_reg     <= sum_next;
        value_reg   <= value_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Configuration registers; the port is always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SIDE_LENGTH_RST;
            tol_reg   <= TOLERANCE_RST;
            maxsw_reg <= MAX_SWEEPS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SIDE_LENGTH: side_reg  <= cfg_data[4:0];
                CFG_TOLERANCE:   tol_reg   <= cfg_data;
                CFG_MAX_SWEEPS:  maxsw_reg <= cfg_data[7:0];
                default:         side_reg  <= side_reg;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Only one buffer is written in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(we_a && we_b))
        else $error("both grid buffers written in one cycle");

    // A sweep never writes into the buffer it is reading from.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SW_CHK || state_reg == ST_SW_WR) && wr_en) |-> (wr_sel != cur_reg))
        else $error("sweep wrote into its source buffer");

    // Every finished sweep swaps the buffers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_END) |=> (cur_reg != $past(cur_reg)))
        else $error("buffer select did not swap after a sweep");

    // The neighbour counter stays within the six face neighbours.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_NB) |-> (nbr_reg <= NBR_ZP))
        else $error("neighbour counter ran past the last face");

endmodule

FILE: design/jlr3d_div6.sv
// ----------------------------------------------------------------------------
// jlr3d_div6
// Floor division of a six-neighbour sum by six, by halving and a reciprocal
// multiply, with the product registered.
// ----------------------------------------------------------------------------
module jlr3d_div6 #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic [VALUE_BITS+2:0] sum,
    output logic [VALUE_BITS-1:0] mean
);

    localparam int HW    = VALUE_BITS + 2;
    localparam int PW    = 2 * HW;
    localparam int SHIFT = VALUE_BITS + 3;
    // ceil(2^SHIFT / 3); the error term stays below one third for any half sum.
    localparam logic [HW-1:0] RECIP = HW'(((64'd1 << SHIFT) + 64'd2) / 64'd3);

    logic [HW-1:0] half_sum;
    logic [PW-1:0] prod_reg;

    assign half_sum = sum[VALUE_BITS+2:1];

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(half_sum) * PW'(RECIP);
    end

    assign mean = prod_reg[SHIFT +: VALUE_BITS];

endmodule
